// ===== hdl/csd_pkg.sv =====
// ----------------------------------------------------------------------------
// csd_pkg
// Shared widths, register map, reset values and types of the clap sequence
// detector.
// ----------------------------------------------------------------------------
package csd_pkg;

	localparam int SAMPLE_W = 12;
	localparam int MAG_W    = 13;
	localparam int WIN_W    = 10;
	localparam int COOL_W   = 8;
	localparam int OFFS_W   = 13;
	localparam int COUNT_W  = 8;

	localparam logic [SAMPLE_W-1:0] MIDSCALE = SAMPLE_W'(2048);
	localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

	// register map, index = paddr[3:2]
	localparam int          ADDR_W       = 4;
	localparam int          DATA_W       = 32;
	localparam logic [1:0]  REG_SEQ_WIN  = 2'd0;
	localparam logic [1:0]  REG_COOLDOWN = 2'd1;
	localparam logic [1:0]  REG_OFFSET   = 2'd2;

	localparam logic [WIN_W-1:0]  SEQ_WIN_RST  = WIN_W'(320);
	localparam logic [COOL_W-1:0] COOLDOWN_RST = COOL_W'(5);
	localparam logic [OFFS_W-1:0] OFFSET_RST   = OFFS_W'(1024);

	typedef struct packed {
		logic [WIN_W-1:0]  sequence_window;
		logic [COOL_W-1:0] cooldown_length;
		logic [OFFS_W-1:0] threshold_offset;
	} cfg_t;

	typedef struct packed {
		logic               seen;
		logic               started;
		logic               ended;
		logic [COUNT_W-1:0] total;
	} seq_res_t;

endpackage

// ===== hdl/csd_regs.sv =====
// ----------------------------------------------------------------------------
// csd_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module csd_regs import csd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sequence_window  <= SEQ_WIN_RST;
			cfg_q.cooldown_length  <= COOLDOWN_RST;
			cfg_q.threshold_offset <= OFFSET_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SEQ_WIN:  cfg_q.sequence_window  <= pwdata[WIN_W-1:0];
				REG_COOLDOWN: cfg_q.cooldown_length  <= pwdata[COOL_W-1:0];
				REG_OFFSET:   cfg_q.threshold_offset <= pwdata[OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SEQ_WIN:  prdata = DATA_W'(cfg_q.sequence_window);
			REG_COOLDOWN: prdata = DATA_W'(cfg_q.cooldown_length);
			REG_OFFSET:   prdata = DATA_W'(cfg_q.threshold_offset);
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== hdl/csd_avg.sv =====
// ----------------------------------------------------------------------------
// csd_avg
// Magnitude history ring, running sum and threshold compare.
// ----------------------------------------------------------------------------
module csd_avg import csd_pkg::*; #(
	parameter int AVERAGE_SPAN = 50
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [MAG_W-1:0]  mag,
	input  logic [OFFS_W-1:0] offset,
	output logic              above
);

	localparam int DEPTH = AVERAGE_SPAN - 1;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W = $clog2(4096 * DEPTH + 1);
	localparam int K_W   = MAG_W;
	localparam int S_W   = $clog2(AVERAGE_SPAN + 1);
	localparam int CMP_W = K_W + S_W;

	logic [MAG_W-1:0] mem [DEPTH];
	logic [MAG_W-1:0] rd_raw_q;
	logic [MAG_W-1:0] byp_data_q;
	logic             byp_q;
	logic [PW-1:0]    pos_q;
	logic [PW-1:0]    pos_inc;
	logic [PW-1:0]    rd_addr;
	logic             wrap;
	logic             full_q;
	logic [SUM_W-1:0] sum_q;
	logic [MAG_W-1:0] oldest;
	logic [MAG_W:0]   diff_p1;
	logic [K_W-1:0]   half_up;
	logic [CMP_W-1:0] bound;

	assign wrap    = (pos_q == PW'(DEPTH - 1));
	assign pos_inc = wrap ? '0 : pos_q + 1'b1;
	// fetch the entry the next sample will replace
	assign rd_addr = advance ? pos_inc : pos_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			mem[pos_q] <= mag;
		end
		rd_raw_q   <= mem[rd_addr];
		byp_q      <= advance && (rd_addr == pos_q);
		byp_data_q <= mag;
	end

	// entries not yet written since reset read as zero
	assign oldest = !full_q ? '0 : (byp_q ? byp_data_q : rd_raw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
		end else if (advance) begin
			pos_q  <= pos_inc;
			full_q <= full_q | wrap;
			sum_q  <= sum_q - SUM_W'(oldest) + SUM_W'(mag);
		end
	end

	// mag > 2*(sum/span) + offset  <=>  sum < span * ceil((mag-offset)/2)
	assign diff_p1 = {1'b0, mag} - {1'b0, offset} + 1'b1;
	assign half_up = diff_p1[MAG_W:1];
	assign bound   = CMP_W'(half_up) * CMP_W'(AVERAGE_SPAN);
	assign above   = (mag > offset) && (CMP_W'(sum_q) < bound);

`ifndef SYNTH
	a_wrap_to_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full_q) |-> (pos_q == '0))
		else $error("history fill flag set away from ring start");
`endif

endmodule

// ===== hdl/csd_seq.sv =====
// ----------------------------------------------------------------------------
// csd_seq
// Cooldown, sequence window and clap counting for each request.
// ----------------------------------------------------------------------------
module csd_seq import csd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  logic     above,
	input  cfg_t     cfg,
	output seq_res_t res
);

	logic [COOL_W-1:0]  cd_q;
	logic [WIN_W-1:0]   win_q;
	logic [COUNT_W-1:0] cnt_q;

	logic [WIN_W-1:0]   win_len;
	logic [WIN_W-1:0]   win_open;
	logic [WIN_W-1:0]   win_dec;
	logic [COUNT_W-1:0] cnt_inc;
	logic [COOL_W-1:0]  cd_next;
	logic [WIN_W-1:0]   win_next;
	logic [COUNT_W-1:0] cnt_next;

	always_comb begin
		win_len = (cfg.sequence_window == '0) ? WIN_W'(1) : cfg.sequence_window;

		res.seen    = (cd_q == '0) && above;
		res.started = res.seen && (win_q == '0);
		res.ended   = 1'b0;
		res.total   = '0;

		if (cd_q == '0) begin
			cd_next = res.seen ? cfg.cooldown_length : '0;
		end else begin
			cd_next = cd_q - 1'b1;
		end

		win_open = res.started ? win_len : win_q;
		cnt_inc  = (res.seen && (cnt_q != COUNT_MAX)) ? cnt_q + 1'b1 : cnt_q;
		win_dec  = win_open - 1'b1;
		win_next = win_open;
		cnt_next = cnt_inc;

		if (win_open != '0) begin
			win_next = win_dec;
			if (win_dec == '0) begin
				res.ended = 1'b1;
				res.total = cnt_inc;
				cnt_next  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q  <= '0;
			win_q <= '0;
			cnt_q <= '0;
		end else if (advance) begin
			cd_q  <= cd_next;
			win_q <= win_next;
			cnt_q <= cnt_next;
		end
	end

`ifndef SYNTH
	a_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (win_q != '0))
		else $error("claps pending with no open window");

	a_cooldown_load: assert property (@(posedge clk) disable iff (!arst_n)
		($past(advance) && $past(res.seen)) |-> (cd_q == $past(cfg.cooldown_length)))
		else $error("cooldown not loaded after a clap");
`endif

endmodule

// ===== hdl/clap_sequence_detector_core.sv =====
// ----------------------------------------------------------------------------
// clap_sequence_detector_core
// Rectifies microphone samples, detects claps against an adaptive threshold
// and reports clap totals per sequence window.
// ----------------------------------------------------------------------------
// path: sample registered in the input stage, result in the result register
// throughput: one sample per cycle while results are taken; input stage and
//   result register let the next sample in while a result waits to be taken
// reset: counters, sum and ring pointer cleared at once, history reads as
//   zero until written (fill flag, no clearing pass), registers to defaults
module clap_sequence_detector_core import csd_pkg::*; #(
	parameter int AVERAGE_SPAN = 50
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic [SAMPLE_W-1:0] mic_sample,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [MAG_W-1:0]    magnitude,
	output logic                clap_seen,
	output logic                sequence_started,
	output logic                sequence_ended,
	output logic [COUNT_W-1:0]  clap_total
);

	cfg_t                cfg;
	seq_res_t            res;
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                valid_s2;
	logic [MAG_W-1:0]    mag_s2;
	seq_res_t            res_s2;
	logic                advance;
	logic [MAG_W-1:0]    mag;
	logic                above;

	csd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance      = valid_s1 && (!valid_s2 || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= mic_sample;
		end
	end

	// |sample - midscale| * 2
	always_comb begin
		if (sample_s1 >= MIDSCALE) begin
			mag = {MAG_W'(sample_s1 - MIDSCALE)} << 1;
		end else begin
			mag = {MAG_W'(MIDSCALE - sample_s1)} << 1;
		end
	end

	csd_avg #(
		.AVERAGE_SPAN (AVERAGE_SPAN)
	) u_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.mag     (mag),
		.offset  (cfg.threshold_offset),
		.above   (above)
	);

	csd_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.above   (above),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s2 <= mag;
			res_s2 <= res;
		end
	end

	assign result_valid     = valid_s2;
	assign magnitude        = mag_s2;
	assign clap_seen        = res_s2.seen;
	assign sequence_started = res_s2.started;
	assign sequence_ended   = res_s2.ended;
	assign clap_total       = res_s2.total;

`ifndef SYNTH
	a_start_needs_clap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && sequence_started) |-> clap_seen)
		else $error("sequence opened without a clap");

	a_total_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !sequence_ended) |-> (clap_total == '0))
		else $error("clap total reported outside a sequence end");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clap sequence detector: a directed table, a
// saturating clap run, then random loud/quiet bursts across several register
// settings, every result checked against its table row or an in-bench model
// of the rectifier, the adaptive threshold and the sequence counters.
// ----------------------------------------------------------------------------
module tb_top import csd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AVG_SPAN     = 50;
	localparam int HIST_DEPTH   = AVG_SPAN - 1;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 10;
	localparam int SAT_WINDOW   = 600;
	localparam int SAT_ITEMS    = 640;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 180;

	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;
	typedef enum logic [1:0] {BURST_QUIET, BURST_LOUD, BURST_NOISE} burst_e;

	typedef struct packed {
		logic [MAG_W-1:0]   magnitude;
		logic               seen;
		logic               started;
		logic               ended;
		logic [COUNT_W-1:0] total;
	} clap_res_t;

	typedef struct packed {
		row_kind_e           kind;
		logic [1:0]          reg_idx;
		logic [DATA_W-1:0]   value;
		logic [SAMPLE_W-1:0] sample;
		logic                typed;
		clap_res_t           res;
	} row_t;

	localparam clap_res_t NO_RES = '0;

	localparam row_t DIRECTED [30] = '{
		// window of one, no cooldown, twice the average as threshold
		'{ROW_CFG, REG_SEQ_WIN, 32'd1, '0, 1'b0, NO_RES},
		'{ROW_CFG, REG_COOLDOWN, 32'd0, '0, 1'b0, NO_RES},
		'{ROW_CFG, REG_OFFSET, 32'd0, '0, 1'b0, NO_RES},
		'{ROW_CFG, REG_UNUSED, 32'hffff_ffff, '0, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd2048, 1'b1, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd0, 1'b1, '{13'd4096, 1'b1, 1'b1, 1'b1, 8'd1}},
		'{ROW_SAMPLE, '0, '0, 12'd4095, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd2049, 1'b0, NO_RES},
		// zero window behaves as one
		'{ROW_CFG, REG_SEQ_WIN, 32'd0, '0, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd0, 1'b0, NO_RES},
		// top of every register: threshold out of reach
		'{ROW_CFG, REG_SEQ_WIN, 32'd1023, '0, 1'b0, NO_RES},
		'{ROW_CFG, REG_COOLDOWN, 32'd255, '0, 1'b0, NO_RES},
		'{ROW_CFG, REG_OFFSET, 32'd8191, '0, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd0, 1'b1, '{13'd4096, 1'b0, 1'b0, 1'b0, 8'd0}},
		'{ROW_SAMPLE, '0, '0, 12'd4095, 1'b1, '{13'd4094, 1'b0, 1'b0, 1'b0, 8'd0}},
		'{ROW_SAMPLE, '0, '0, 12'd2047, 1'b1, '{13'd2, 1'b0, 1'b0, 1'b0, 8'd0}},
		'{ROW_SAMPLE, '0, '0, 12'd2048, 1'b1, NO_RES},
		// short window filled by back-to-back claps
		'{ROW_CFG, REG_SEQ_WIN, 32'd3, '0, 1'b0, NO_RES},
		'{ROW_CFG, REG_COOLDOWN, 32'd0, '0, 1'b0, NO_RES},
		'{ROW_CFG, REG_OFFSET, 32'd0, '0, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd0, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd4095, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd0, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd2048, 1'b0, NO_RES},
		// cooldown masks loud samples inside the window
		'{ROW_CFG, REG_COOLDOWN, 32'd2, '0, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd0, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd0, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd4095, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd0, 1'b0, NO_RES},
		'{ROW_SAMPLE, '0, '0, 12'd2048, 1'b0, NO_RES}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                sample_valid;
	logic                sample_ready;
	logic [SAMPLE_W-1:0] mic_sample;
	logic                result_valid;
	logic                result_ready;
	logic [MAG_W-1:0]    magnitude;
	logic                clap_seen;
	logic                sequence_started;
	logic                sequence_ended;
	logic [COUNT_W-1:0]  clap_total;

	// detector model state
	cfg_t               cfg_model;
	logic [MAG_W-1:0]   mag_hist [HIST_DEPTH];
	int unsigned        hist_wr;
	logic [31:0]        mag_sum;
	logic [COOL_W-1:0]  cool_left;
	logic [WIN_W-1:0]   win_left;
	logic [COUNT_W-1:0] clap_cnt;

	clap_res_t awaited_results [$];
	int        mismatches;
	logic      send_calm;
	logic      take_calm;

	clap_sequence_detector_core #(.AVERAGE_SPAN(AVG_SPAN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.mic_sample(mic_sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.magnitude(magnitude),
		.clap_seen(clap_seen),
		.sequence_started(sequence_started),
		.sequence_ended(sequence_ended),
		.clap_total(clap_total)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// threshold uses the previous samples only, then the current one enters the ring
	function automatic clap_res_t rectify_and_detect(input logic [SAMPLE_W-1:0] s);
		clap_res_t        r;
		int unsigned      raw;
		logic [31:0]      thr;
		logic [WIN_W-1:0] win_len;
		r = '0;
		raw = s;
		r.magnitude = MAG_W'((raw >= MIDSCALE) ? (raw - MIDSCALE) * 2 : (MIDSCALE - raw) * 2);
		thr = (mag_sum / AVG_SPAN) * 2 + 32'(cfg_model.threshold_offset);
		win_len = (cfg_model.sequence_window == '0) ? WIN_W'(1) : cfg_model.sequence_window;
		mag_sum = mag_sum - 32'(mag_hist[hist_wr]) + 32'(r.magnitude);
		mag_hist[hist_wr] = r.magnitude;
		hist_wr = (hist_wr == HIST_DEPTH - 1) ? 0 : hist_wr + 1;
		if (cool_left == '0) begin
			if (32'(r.magnitude) > thr) begin
				r.seen = 1'b1;
				cool_left = cfg_model.cooldown_length;
				if (win_left == '0) begin
					win_left = win_len;
					r.started = 1'b1;
				end
				if (clap_cnt != COUNT_MAX)
					clap_cnt++;
			end
		end else begin
			cool_left--;
		end
		// the opening sample already counts against the window
		if (win_left != '0) begin
			win_left--;
			if (win_left == '0) begin
				r.ended = 1'b1;
				r.total = clap_cnt;
				clap_cnt = '0;
			end
		end
		return r;
	endfunction

	task automatic apb_cycle(input logic wr, input logic [1:0] idx,
			input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] want;
		logic              known;
		apb_cycle(1'b1, idx, data, rd);
		known = 1'b1;
		want = '0;
		case (idx)
			REG_SEQ_WIN: begin
				cfg_model.sequence_window = data[WIN_W-1:0];
				want = DATA_W'(cfg_model.sequence_window);
			end
			REG_COOLDOWN: begin
				cfg_model.cooldown_length = data[COOL_W-1:0];
				want = DATA_W'(cfg_model.cooldown_length);
			end
			REG_OFFSET: begin
				cfg_model.threshold_offset = data[OFFS_W-1:0];
				want = DATA_W'(cfg_model.threshold_offset);
			end
			default: known = 1'b0;
		endcase
		if (known) begin
			apb_cycle(1'b0, idx, '0, rd);
			if (rd !== want) begin
				$error("prdata: expected %0d, actual %0d", want, rd);
				mismatches++;
			end
		end
	endtask

	// registers only change once every pending request has produced its result
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
			input clap_res_t want);
		int        gap;
		clap_res_t pred;
		if ($urandom_range(0, 39) == 0)
			send_calm = ~send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		mic_sample <= s;
		do @(posedge clk); while (!sample_ready);
		pred = rectify_and_detect(s);
		awaited_results.push_back(typed ? want : pred);
	endtask

	initial begin : result_taker
		int        stall;
		clap_res_t want;
		result_ready <= 1'b0;
		take_calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				take_calm = ~take_calm;
			stall = take_calm ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			if (awaited_results.size() == 0) begin
				$error("result with no request pending: magnitude %0d", magnitude);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				if (magnitude !== want.magnitude) begin
					$error("magnitude: expected %0d, actual %0d", want.magnitude, magnitude);
					mismatches++;
				end
				if (clap_seen !== want.seen) begin
					$error("clap_seen: expected %0d, actual %0d", want.seen, clap_seen);
					mismatches++;
				end
				if (sequence_started !== want.started) begin
					$error("sequence_started: expected %0d, actual %0d", want.started,
						sequence_started);
					mismatches++;
				end
				if (sequence_ended !== want.ended) begin
					$error("sequence_ended: expected %0d, actual %0d", want.ended,
						sequence_ended);
					mismatches++;
				end
				if (clap_total !== want.total) begin
					$error("clap_total: expected %0d, actual %0d", want.total, clap_total);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && sample_ready) || (result_valid && result_ready) || psel
					|| !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int                  i;
		int                  pick;
		int                  run_left;
		burst_e              run_kind;
		logic [SAMPLE_W-1:0] s;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample_valid <= 1'b0;
		mic_sample <= '0;
		send_calm = 1'b0;
		mismatches = 0;
		cfg_model = '{SEQ_WIN_RST, COOLDOWN_RST, OFFSET_RST};
		foreach (mag_hist[k])
			mag_hist[k] = '0;
		hist_wr = 0;
		mag_sum = '0;
		cool_left = '0;
		win_left = '0;
		clap_cnt = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[r]) begin
			if (DIRECTED[r].kind == ROW_CFG) begin
				drain_results();
				write_reg(DIRECTED[r].reg_idx, DIRECTED[r].value);
			end else begin
				send_sample(DIRECTED[r].sample, DIRECTED[r].typed, DIRECTED[r].res);
			end
		end

		// alternate full-scale and near-silent samples: each loud one beats twice
		// the average, so the count runs past saturation inside one window
		drain_results();
		write_reg(REG_SEQ_WIN, SAT_WINDOW);
		write_reg(REG_COOLDOWN, 0);
		write_reg(REG_OFFSET, 0);
		for (i = 0; i < SAT_ITEMS; i++) begin
			if (i % 2 == 0)
				s = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(0, 15))
					: SAMPLE_W'($urandom_range(4080, 4095));
			else
				s = SAMPLE_W'(2040 + $urandom_range(0, 16));
			send_sample(s, 1'b0, NO_RES);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			pick = $urandom_range(0, 9);
			write_reg(REG_SEQ_WIN, (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 1023
				: $urandom_range(2, 80));
			pick = $urandom_range(0, 9);
			write_reg(REG_COOLDOWN, (pick == 0) ? 255 : $urandom_range(0, 12));
			pick = $urandom_range(0, 9);
			write_reg(REG_OFFSET, (pick == 0) ? 8191 : (pick == 1) ? 0
				: $urandom_range(0, 2500));
			run_left = 0;
			run_kind = BURST_QUIET;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				// quiet background broken by short clap bursts and some raw noise
				if (run_left == 0) begin
					pick = $urandom_range(0, 9);
					run_kind = (pick < 6) ? BURST_QUIET : (pick < 8) ? BURST_LOUD : BURST_NOISE;
					run_left = (run_kind == BURST_QUIET) ? $urandom_range(1, 30)
						: $urandom_range(1, 3);
				end
				run_left--;
				case (run_kind)
					BURST_QUIET: s = SAMPLE_W'(2008 + $urandom_range(0, 80));
					BURST_LOUD: s = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(0, 400))
						: SAMPLE_W'($urandom_range(3695, 4095));
					default: s = SAMPLE_W'($urandom_range(0, 4095));
				endcase
				send_sample(s, 1'b0, NO_RES);
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
